FILE: hw/rtl/pdlb_pkg.sv
// ----------------------------------------------------------------------------
// pdlb_pkg
// Types and fixed widths shared by the partial-distance lower-bound unit.
// ----------------------------------------------------------------------------
package pdlb_pkg;

    localparam int COORD_W = 16;               // signed Q8.8 coordinate
    localparam int SPLIT_W = 11;               // split_dim register
    localparam int SUM_W   = 44;               // diff_sum and result
    localparam int NORM_W  = 42;               // tail norms
    localparam int DSQ_W   = 32;               // square of a coordinate difference
    localparam int CSQ_W   = 31;               // square of one coordinate
    localparam int HALF_W  = NORM_W / 2;       // multiplier operand chunk
    localparam int PROD_W  = 2 * NORM_W;       // norm product
    localparam int ROOT_W  = NORM_W;           // root of the norm product
    localparam int REM_W   = ROOT_W + 2;       // square-root remainder
    localparam int TERM_W  = NORM_W + 1;       // na + nb - 2 * root
    localparam int CNT_W   = $clog2(ROOT_W);   // step counter
    localparam int S_DATA_W = 2 * COORD_W;
    localparam int M_DATA_W = ((SUM_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_MUL,
        ST_ROOT,
        ST_TERM,
        ST_FINAL
    } pdlb_state_t;

    typedef struct packed {
        logic take;       // input transaction this cycle
        logic clr_root;   // clear product, remainder and root
        logic cnt_clr;    // restart step counter
        logic mul_step;   // add one partial product
        logic root_step;  // one bit of the square root
        logic term;       // form na + nb - 2 * root
        logic finish;     // load result, clear vector state
    } pdlb_cmd_t;

    typedef struct packed {
        logic mul_last;
        logic root_last;
        logic out_free;
    } pdlb_stat_t;

endpackage

FILE: hw/rtl/pdlb_ctrl.sv
// ----------------------------------------------------------------------------
// pdlb_ctrl
// Sequencer: streams coordinate pairs, then runs multiply, root and result.
// ----------------------------------------------------------------------------
module pdlb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  pdlb_pkg::pdlb_stat_t stat,
    output pdlb_pkg::pdlb_cmd_t  cmd
);
    import pdlb_pkg::*;

    pdlb_state_t state_reg;
    pdlb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (stat.mul_last) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (stat.root_last) begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (stat.out_free) begin
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_ACCUM: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_DRAIN: begin
                cmd.clr_root = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cmd.cnt_clr  = stat.mul_last;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
            end
            ST_TERM: begin
                cmd.term = 1'b1;
            end
            ST_FINAL: begin
                cmd.finish = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pdlb_datapath.sv
// ----------------------------------------------------------------------------
// pdlb_datapath
// Squares, saturating sums, chunked norm product, bit-serial root, result.
// ----------------------------------------------------------------------------
module pdlb_datapath #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [pdlb_pkg::SPLIT_W-1:0]        cfg_data,
    input  logic [pdlb_pkg::S_DATA_W-1:0]       s_tdata,
    input  pdlb_pkg::pdlb_cmd_t                 cmd,
    output pdlb_pkg::pdlb_stat_t                stat,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [pdlb_pkg::M_DATA_W-1:0]       m_tdata
);
    import pdlb_pkg::*;

    localparam int PW = $clog2(MAX_DIM + 1);
    localparam int CW = (PW > SPLIT_W) ? PW : SPLIT_W;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [NORM_W-1:0] NORM_MAX = '1;

    logic [SPLIT_W-1:0] split_reg;
    logic [PW-1:0]      pos_reg;
    logic               sq_vld_reg;
    logic               sq_tail_reg;
    logic [DSQ_W-1:0]   sq_diff_reg;
    logic [CSQ_W-1:0]   sq_a_reg;
    logic [CSQ_W-1:0]   sq_b_reg;
    logic [SUM_W-1:0]   diff_sum_reg;
    logic [NORM_W-1:0]  norm_a_reg;
    logic [NORM_W-1:0]  norm_b_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W-1:0]  root_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TERM_W-1:0]  term_reg;
    logic [TERM_W-1:0]  term_next;
    logic               out_vld_reg;
    logic [SUM_W-1:0]   out_reg;
    logic [SUM_W-1:0]   out_next;

    logic signed [COORD_W-1:0]   a_in;
    logic signed [COORD_W-1:0]   b_in;
    logic signed [COORD_W:0]     d_in;
    logic signed [2*COORD_W+1:0] d_sq;
    logic signed [2*COORD_W-1:0] a_sq;
    logic signed [2*COORD_W-1:0] b_sq;
    logic                        in_head;

    logic [SUM_W:0]            diff_sum_add;
    logic [NORM_W:0]           norm_a_add;
    logic [NORM_W:0]           norm_b_add;
    logic [HALF_W-1:0]         mul_a;
    logic [HALF_W-1:0]         mul_b;
    logic [2*HALF_W-1:0]       mul_pp;
    logic [PROD_W-1:0]         mul_pp_sh;
    logic [REM_W+1:0]          rem_sh;
    logic [REM_W+1:0]          trial;
    logic [TERM_W-1:0]         norm_sum;
    logic [TERM_W-1:0]         twice_root;
    logic [SUM_W:0]            final_add;

    // ---- input squares, one multiplier per lane ----
    assign a_in = s_tdata[COORD_W-1:0];
    assign b_in = s_tdata[2*COORD_W-1:COORD_W];
    assign d_in = {a_in[COORD_W-1], a_in} - {b_in[COORD_W-1], b_in};
    assign d_sq = d_in * d_in;
    assign a_sq = a_in * a_in;
    assign b_sq = b_in * b_in;
    assign in_head = CW'(pos_reg) < CW'(split_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_reg <= '0;
        end else if (cfg_valid) begin
            split_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sq_vld_reg <= 1'b0;
        end else begin
            sq_vld_reg <= cmd.take;
            if (cmd.finish) begin
                pos_reg <= '0;
            end else if (cmd.take && (pos_reg != PW'(MAX_DIM))) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sq_tail_reg <= !in_head;
            sq_diff_reg <= d_sq[DSQ_W-1:0];
            sq_a_reg    <= a_sq[CSQ_W-1:0];
            sq_b_reg    <= b_sq[CSQ_W-1:0];
        end
    end

    // ---- saturating accumulation, in the cycle after the squares ----
    assign diff_sum_add = {1'b0, diff_sum_reg} + (SUM_W + 1)'(sq_diff_reg);
    assign norm_a_add   = {1'b0, norm_a_reg} + (NORM_W + 1)'(sq_a_reg);
    assign norm_b_add   = {1'b0, norm_b_reg} + (NORM_W + 1)'(sq_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_sum_reg <= '0;
            norm_a_reg   <= '0;
            norm_b_reg   <= '0;
        end else if (cmd.finish) begin
            diff_sum_reg <= '0;
            norm_a_reg   <= '0;
            norm_b_reg   <= '0;
        end else if (sq_vld_reg) begin
            if (sq_tail_reg) begin
                norm_a_reg <= norm_a_add[NORM_W] ? NORM_MAX : norm_a_add[NORM_W-1:0];
                norm_b_reg <= norm_b_add[NORM_W] ? NORM_MAX : norm_b_add[NORM_W-1:0];
            end else begin
                diff_sum_reg <= diff_sum_add[SUM_W] ? SUM_MAX : diff_sum_add[SUM_W-1:0];
            end
        end
    end

    // ---- norm product: four half-width partial products ----
    assign mul_a  = cnt_reg[1] ? norm_a_reg[NORM_W-1:HALF_W] : norm_a_reg[HALF_W-1:0];
    assign mul_b  = cnt_reg[0] ? norm_b_reg[NORM_W-1:HALF_W] : norm_b_reg[HALF_W-1:0];
    assign mul_pp = mul_a * mul_b;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    mul_pp_sh = PROD_W'(mul_pp);
            2'd3:    mul_pp_sh = PROD_W'(mul_pp) << (2 * HALF_W);
            default: mul_pp_sh = PROD_W'(mul_pp) << HALF_W;
        endcase
    end

    // ---- restoring square root, two radicand bits per step ----
    assign rem_sh = {rem_reg, prod_reg[PROD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (cmd.clr_root) begin
            prod_next = '0;
            rem_next  = '0;
            root_next = '0;
        end else if (cmd.mul_step) begin
            prod_next = prod_reg + mul_pp_sh;
        end else if (cmd.root_step) begin
            prod_next = prod_reg << 2;
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.mul_step || cmd.root_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // ---- na + nb - 2 * root, clamped at zero ----
    assign norm_sum   = {1'b0, norm_a_reg} + {1'b0, norm_b_reg};
    assign twice_root = {root_reg, 1'b0};
    assign term_next  = (norm_sum > twice_root) ? (norm_sum - twice_root) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.term) begin
            term_reg <= term_next;
        end
    end

    // ---- result register ----
    assign final_add = {1'b0, diff_sum_reg} + (SUM_W + 1)'(term_reg);
    assign out_next  = final_add[SUM_W] ? SUM_MAX : final_add[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    assign stat.mul_last  = (cnt_reg[1:0] == 2'd3);
    assign stat.root_last = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign stat.out_free  = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DATA_W'(out_reg);

endmodule

FILE: hw/rtl/partial_distance_lower_bound_unit.sv
// ----------------------------------------------------------------------------
// partial_distance_lower_bound_unit
// Streams coordinate pairs of two vectors and returns a lower bound on their
// squared distance: exact head differences plus a norm bound over the tail.
//
//   channel  dir  width  contents
//   s_       in   32     coord_a, coord_b; tlast = last_coord
//   m_       out  48     lower_bound (44 bits, zero padded)
//   cfg_     in   11     split_dim
//
// Pairs are taken one per cycle while not stalled. After the pair marked last,
// input stalls through the last accumulate, 4 partial products of the norm
// product, 42 bit-serial square-root steps, the norm term and the result load.
// The result register lets the next vector stream while a result waits; a
// second finish holds until it has been taken. cfg_ready is always high.
// Reset is synchronous, active low; split_dim and all sums clear to zero.
// ----------------------------------------------------------------------------
module partial_distance_lower_bound_unit #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdlb_pkg::SPLIT_W-1:0]        cfg_data,   // split_dim
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pdlb_pkg::S_DATA_W-1:0]       s_tdata,    // coord_a, coord_b
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pdlb_pkg::M_DATA_W-1:0]       m_tdata     // lower_bound, pad
);
    import pdlb_pkg::*;

    pdlb_cmd_t  cmd;
    pdlb_stat_t stat;

    assign cfg_ready = 1'b1;

    pdlb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdlb_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // a closing pair must stall the stream while the bound is formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted straight after a closing pair");

    // a fresh result is only loaded while the stream is held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while streaming");

    // take, step, term and finish commands are mutually exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.mul_step, cmd.root_step, cmd.term, cmd.finish}))
        else $error("overlapping datapath commands");
`endif

endmodule
